/* rtl/rtc_pkg.sv */
// shared types, character codes and count helpers of the regex token classifier
// no dependencies
package rtc_pkg;

  localparam int unsigned COUNT_MAX = 255;
  localparam int unsigned CNT_W     = $clog2(COUNT_MAX + 1);
  localparam int unsigned POS_MAX   = 255;

  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_LO_W    = 8'h77;
  localparam logic [7:0] CH_LO_D    = 8'h64;
  localparam logic [7:0] CH_LO_S    = 8'h73;
  localparam logic [7:0] CH_UP_W    = 8'h57;
  localparam logic [7:0] CH_UP_D    = 8'h44;
  localparam logic [7:0] CH_UP_S    = 8'h53;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic       lone_char;
    logic       wildcard_res;
    logic       escaped_pair;
    logic       category;
    logic       negated_category;
    logic       closed_bracket;
    logic       negated_class;
    logic       class_valid;
    logic [7:0] item_count;
  } res_t;

  function automatic cnt_t sat_add(input cnt_t x, input logic [1:0] n);
    logic [CNT_W:0] s;
    begin
      s = {1'b0, x} + (CNT_W + 1)'(n);
      if (s > (CNT_W + 1)'(COUNT_MAX)) begin
        sat_add = CNT_W'(COUNT_MAX);
      end else begin
        sat_add = s[CNT_W-1:0];
      end
    end
  endfunction

endpackage

/* rtl/regex_token_classifier.sv */
// regex token classifier: one character word per cycle in, one result per token out
// a last word waits in the input register until the result register is free
// throughput: one word per cycle, set by the single-pass parser, bar such waits
// reset: synchronous active-low rst_n clears token state and both valid registers
// depends on rtc_pkg, rtc_in_stage, rtc_parser, rtc_out_stage
module regex_token_classifier import rtc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // ch
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // item_count
  output logic [7:0] out_tuser   // lone_char, wildcard_res, escaped_pair, category,
                                 // negated_category, closed_bracket, negated_class,
                                 // class_valid
);

  in_word_t in_word, s1_word;
  logic     s1_valid, adv, load, free;
  res_t     res, res_q;

  assign in_word.ch   = in_tdata;
  assign in_word.last = in_tlast;

  assign adv  = s1_valid && (!s1_word.last || free);
  assign load = s1_valid && s1_word.last && free;

  rtc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_word   (in_word),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_word   (s1_word)
  );

  rtc_parser u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .word  (s1_word),
    .res   (res)
  );

  rtc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .res_in     (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_out    (res_q)
  );

  assign out_tdata = res_q.item_count;
  assign out_tuser = {res_q.class_valid, res_q.negated_class, res_q.closed_bracket,
                      res_q.negated_category, res_q.category, res_q.escaped_pair,
                      res_q.wildcard_res, res_q.lone_char};

endmodule

/* rtl/rtc_in_stage.sv */
// input register of the regex token classifier
// depends on rtc_pkg
module rtc_in_stage import rtc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  in_word_t in_word,
  input  logic     adv,
  output logic     s1_valid,
  output in_word_t s1_word
);

  logic     valid_r, valid_nxt;
  in_word_t word_r;
  logic     take;

  assign in_tready = !valid_r || adv;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      word_r <= in_word;
    end
  end

  assign s1_valid = valid_r;
  assign s1_word  = word_r;

endmodule

/* rtl/rtc_parser.sv */
// token state and classification logic of the regex token classifier
// depends on rtc_pkg
module rtc_parser import rtc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  in_word_t word,
  output res_t     res
);

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic       early_r, early_nxt;
  logic [7:0] pend0_r, pend0_nxt;
  logic [1:0] pcnt_r, pcnt_nxt;
  cnt_t       items_r, items_nxt;
  logic       bad_r, bad_nxt;

  logic [7:0] ch;
  logic       body_act, closing, feed, valid;
  cnt_t       items_fin;
  logic [CNT_W+7:0] items_wide;

  assign ch = word.ch;

  always_comb begin
    first_nxt  = (pos_r == 8'd0) ? ch : first_r;
    second_nxt = (pos_r == 8'd1) ? ch : second_r;
    body_act   = (pos_r != 8'd0) && (first_nxt == CH_LBRACK) && !early_r;
    closing    = body_act && (ch == CH_RBRACK) && word.last;
    early_nxt  = early_r || (body_act && (ch == CH_RBRACK) && !word.last);
    feed       = body_act && (ch != CH_RBRACK) && !((pos_r == 8'd1) && (ch == CH_CARET));

    pend0_nxt = pend0_r;
    pcnt_nxt  = pcnt_r;
    items_nxt = items_r;
    bad_nxt   = bad_r;
    if (feed) begin
      case (pcnt_r)
        2'd0: begin
          pend0_nxt = ch;
          pcnt_nxt  = 2'd1;
        end
        2'd1: begin
          if (ch == CH_DASH) begin
            pcnt_nxt = 2'd2;
          end else if (pend0_r == CH_BSLASH) begin
            items_nxt = sat_add(items_r, 2'd1);
            pcnt_nxt  = 2'd0;
          end else begin
            items_nxt = sat_add(items_r, 2'd1);
            pend0_nxt = ch;
          end
        end
        default: begin
          if (pend0_r <= ch) begin
            items_nxt = sat_add(items_r, 2'd1);
          end else begin
            bad_nxt = 1'b1;
          end
          pcnt_nxt = 2'd0;
        end
      endcase
    end

    // flush of an undecided item start at the closing bracket
    items_fin = items_nxt;
    if (pcnt_r == 2'd1) begin
      items_fin = sat_add(items_nxt, 2'd1);
    end else if (pcnt_r == 2'd2) begin
      items_fin = sat_add(items_nxt, (pend0_r != CH_BSLASH) ? 2'd2 : 2'd1);
    end

    if (pos_r < 8'(POS_MAX)) begin
      pos_nxt = pos_r + 8'd1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  assign valid      = closing && !bad_nxt && (items_fin != '0);
  assign items_wide = (CNT_W + 8)'(items_fin);

  always_comb begin
    res.lone_char = (pos_r == 8'd0) && (ch >= CH_PRINT_LO) && (ch <= CH_PRINT_HI)
                    && (ch != CH_BSLASH) && (ch != CH_LBRACK);
    res.wildcard_res     = res.lone_char && (ch == CH_DOT);
    res.escaped_pair     = (pos_r == 8'd1) && (first_r == CH_BSLASH);
    res.category         = res.escaped_pair
                           && ((ch == CH_LO_W) || (ch == CH_LO_D) || (ch == CH_LO_S));
    res.negated_category = res.escaped_pair
                           && ((ch == CH_UP_W) || (ch == CH_UP_D) || (ch == CH_UP_S));
    res.closed_bracket   = closing;
    res.negated_class    = closing && (second_nxt == CH_CARET);
    res.class_valid      = valid;
    if (!valid) begin
      res.item_count = 8'd0;
    end else if (items_wide > (CNT_W + 8)'(255)) begin
      res.item_count = 8'hFF;
    end else begin
      res.item_count = items_wide[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
      early_r  <= 1'b0;
      pcnt_r   <= '0;
      items_r  <= '0;
      bad_r    <= 1'b0;
    end else if (adv) begin
      if (word.last) begin
        pos_r    <= '0;
        first_r  <= '0;
        second_r <= '0;
        early_r  <= 1'b0;
        pcnt_r   <= '0;
        items_r  <= '0;
        bad_r    <= 1'b0;
      end else begin
        pos_r    <= pos_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
        early_r  <= early_nxt;
        pcnt_r   <= pcnt_nxt;
        items_r  <= items_nxt;
        bad_r    <= bad_nxt;
      end
    end
    if (adv && !word.last) begin
      pend0_r <= pend0_nxt;
    end
  end

endmodule

/* rtl/rtc_out_stage.sv */
// result register of the regex token classifier
// depends on rtc_pkg
module rtc_out_stage import rtc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  output logic free,
  output logic out_tvalid,
  input  logic out_tready,
  output res_t res_out
);

  logic valid_r, valid_nxt;
  res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= res_in;
    end
  end

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign res_out    = res_r;

endmodule

/* rtl/rtc_checker.sv */
// port-level checks of the regex token classifier, bound to the top level
// depends on regex_token_classifier
module rtc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [7:0] out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({out_tuser[0], out_tuser[2], out_tuser[5]}))
    else $error("token classified as more than one kind");

  a_sub_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[1] || out_tuser[0]) && (!(out_tuser[3] || out_tuser[4])
                   || out_tuser[2]) && (!(out_tuser[6] || out_tuser[7]) || out_tuser[5]))
    else $error("sub flag without its token kind");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[7] == (out_tdata != 8'd0)))
    else $error("item count disagrees with class valid");

endmodule

bind regex_token_classifier rtc_checker u_rtc_checker (.*);
